// ===== hdl/picq_pkg.sv =====
`timescale 1ns / 1ps

package picq_pkg;

	localparam int unsigned ErrW   = 17;              // target - sample
	localparam int unsigned SumW   = ErrW + 1;        // e0 + e1, e0 - e1
	localparam int unsigned OpAW   = SumW + 1;        // integral plus difference
	localparam int unsigned OpBW   = 17;              // gain or ts_over_ti, signed
	localparam int unsigned ProdW  = OpAW + OpBW;     // full product
	localparam int unsigned RndW   = ProdW + 1;       // product plus rounding term
	localparam int unsigned DataW  = 16;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned FracW  = 5;
	localparam int unsigned TsW    = 15;
	localparam int unsigned IntShift = 16;

	typedef enum logic [IdxW-1:0] {
		REG_TARGET    = 3'd0,
		REG_TS_OVER_TI = 3'd1,
		REG_GAIN      = 3'd2,
		REG_FRAC_BITS = 3'd3,
		REG_OUT_MAX   = 3'd4,
		REG_OUT_MIN   = 3'd5,
		REG_INVERT    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [DataW-1:0] target;
		logic        [TsW-1:0]   ts_over_ti;
		logic signed [DataW-1:0] gain;
		logic        [FracW-1:0] gain_frac_bits;
		logic signed [DataW-1:0] out_max;
		logic signed [DataW-1:0] out_min;
		logic                    invert;
	} cfg_t;

	localparam logic [FracW-1:0]        FracBitsReset = 5'd15;
	localparam logic signed [DataW-1:0] OutMaxReset   = 16'sh7FFF;
	localparam logic signed [DataW-1:0] OutMinReset   = 16'sh8000;

endpackage

// ===== hdl/picq_cfg.sv =====
`timescale 1ns / 1ps

module picq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [picq_pkg::IdxW-1:0]     cfg_index,
	input  logic [picq_pkg::DataW-1:0]    cfg_data,
	output picq_pkg::cfg_t                cfg
);

	picq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target         <= '0;
			cfg_q.ts_over_ti     <= '0;
			cfg_q.gain           <= '0;
			cfg_q.gain_frac_bits <= picq_pkg::FracBitsReset;
			cfg_q.out_max        <= picq_pkg::OutMaxReset;
			cfg_q.out_min        <= picq_pkg::OutMinReset;
			cfg_q.invert         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				picq_pkg::REG_TARGET:     cfg_q.target <= cfg_data;
				picq_pkg::REG_TS_OVER_TI: cfg_q.ts_over_ti <= cfg_data[picq_pkg::TsW-1:0];
				picq_pkg::REG_GAIN:       cfg_q.gain <= cfg_data;
				picq_pkg::REG_FRAC_BITS:  cfg_q.gain_frac_bits <= cfg_data[picq_pkg::FracW-1:0];
				picq_pkg::REG_OUT_MAX:    cfg_q.out_max <= cfg_data;
				picq_pkg::REG_OUT_MIN:    cfg_q.out_min <= cfg_data;
				picq_pkg::REG_INVERT:     cfg_q.invert <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/picq_mul.sv =====
`timescale 1ns / 1ps

module picq_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [picq_pkg::OpAW-1:0]    op_a,
	input  logic signed [picq_pkg::OpBW-1:0]    op_b,
	output logic signed [picq_pkg::ProdW-1:0]   prod
);

	logic signed [picq_pkg::ProdW-1:0] prod_q;

	// Shared signed multiplier, result registered
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= picq_pkg::ProdW'(op_a) * picq_pkg::ProdW'(op_b);
		end
	end

	assign prod = prod_q;

endmodule

// ===== hdl/incremental_pi_controller_q15_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                                  Content
// s_axis    in         s_tvalid s_tready s_tdata s_tuser      tdata: sample; tuser: func
// m_axis    out        m_tvalid m_tready m_tdata              tdata: drive
// cfg       in         cfg_we cfg_index cfg_data              register write, no read-back
//
// An update item goes from transfer to result in two passes through the
// one shared multiplier (integral term, then gain), each followed by a rounding step,
// then a saturate and clamp step. An init item goes from transfer straight to the emit state.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register while m_tready is low, and the next item may be taken meanwhile.
// Reset clears the error history, the drive and the output valid, and sets the configuration to its defaults.

module incremental_pi_controller_q15_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [picq_pkg::DataW-1:0]         s_tdata,   // [15:0] sample
	input  logic                               s_tuser,   // [0] func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [picq_pkg::DataW-1:0]         m_tdata,   // [15:0] drive
	input  logic                               cfg_we,
	input  logic [picq_pkg::IdxW-1:0]          cfg_index,
	input  logic [picq_pkg::DataW-1:0]         cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_ADD_I,
		ST_MUL_G,
		ST_ROUND,
		ST_SAT,
		ST_EMIT
	} state_t;

	state_t state_q;

	picq_pkg::cfg_t cfg;

	logic signed [picq_pkg::ErrW-1:0]  err_now_q;
	logic signed [picq_pkg::ErrW-1:0]  err_prev_q;
	logic signed [picq_pkg::DataW-1:0] drive_q;
	logic signed [picq_pkg::OpAW-1:0]  acc_q;
	logic signed [picq_pkg::RndW-1:0]  rnd_q;
	logic        [picq_pkg::DataW-1:0] m_tdata_q;
	logic                              m_tvalid_q;

	logic signed [picq_pkg::ErrW-1:0]  err_new;
	logic signed [picq_pkg::SumW-1:0]  err_sum;
	logic signed [picq_pkg::SumW-1:0]  err_diff;
	logic signed [picq_pkg::DataW-1:0] gain_eff;
	logic signed [picq_pkg::OpAW-1:0]  mul_a;
	logic signed [picq_pkg::OpBW-1:0]  mul_b;
	logic                              mul_en;
	logic signed [picq_pkg::ProdW-1:0] prod;
	logic signed [picq_pkg::ProdW-1:0] int_shifted;
	logic signed [picq_pkg::OpAW-1:0]  acc_next;
	logic signed [picq_pkg::RndW-1:0]  half;
	logic signed [picq_pkg::RndW-1:0]  rnd_next;
	logic signed [picq_pkg::RndW:0]    total;
	logic signed [picq_pkg::DataW-1:0] sat16;
	logic signed [picq_pkg::DataW-1:0] drive_next;
	logic                              in_xfer;
	logic                              out_free;

	picq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	picq_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		err_new  = picq_pkg::ErrW'(cfg.target) - picq_pkg::ErrW'($signed(s_tdata));
		err_sum  = picq_pkg::SumW'(err_now_q) + picq_pkg::SumW'(err_prev_q);
		err_diff = picq_pkg::SumW'(err_now_q) - picq_pkg::SumW'(err_prev_q);

		// a positive gain is negated when inverted
		gain_eff = (cfg.invert && (cfg.gain > 0)) ? -cfg.gain : cfg.gain;

		mul_en = (state_q == ST_MUL_I) || (state_q == ST_MUL_G);
		if (state_q == ST_MUL_I) begin
			mul_a = picq_pkg::OpAW'(err_sum);
			mul_b = picq_pkg::OpBW'($signed({1'b0, cfg.ts_over_ti}));
		end else begin
			mul_a = acc_q;
			mul_b = picq_pkg::OpBW'(gain_eff);
		end

		// integral term rounded half up, plus the error difference
		int_shifted = (prod + picq_pkg::ProdW'(32768)) >>> picq_pkg::IntShift;
		acc_next    = int_shifted[picq_pkg::OpAW-1:0] + picq_pkg::OpAW'(err_diff);

		if (cfg.gain_frac_bits == '0) begin
			half = '0;
		end else begin
			half = picq_pkg::RndW'(1) <<< (cfg.gain_frac_bits - 1'b1);
		end
		rnd_next = (picq_pkg::RndW'(prod) + half) >>> cfg.gain_frac_bits;

		total = (picq_pkg::RndW + 1)'(rnd_q) + (picq_pkg::RndW + 1)'(drive_q);
		if (total > (picq_pkg::RndW + 1)'(32767)) begin
			sat16 = 16'sh7FFF;
		end else if (total < -(picq_pkg::RndW + 1)'(32768)) begin
			sat16 = 16'sh8000;
		end else begin
			sat16 = total[picq_pkg::DataW-1:0];
		end

		// upper clamp wins when the limits cross
		if (sat16 > cfg.out_max) begin
			drive_next = cfg.out_max;
		end else if (sat16 < cfg.out_min) begin
			drive_next = cfg.out_min;
		end else begin
			drive_next = sat16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			err_now_q  <= '0;
			err_prev_q <= '0;
			drive_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						err_now_q <= err_new;
						if (s_tuser) begin
							err_prev_q <= err_now_q;
							state_q    <= ST_MUL_I;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL_I: state_q <= ST_ADD_I;
				ST_ADD_I: state_q <= ST_MUL_G;
				ST_MUL_G: state_q <= ST_ROUND;
				ST_ROUND: state_q <= ST_SAT;
				ST_SAT: begin
					drive_q <= drive_next;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADD_I) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_ROUND) begin
			rnd_q <= rnd_next;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= drive_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== tb/incremental_pi_controller_q15_top_tb.sv =====
`timescale 1ns / 1ps

module incremental_pi_controller_q15_top_tb;
	import picq_pkg::*;

	localparam logic FuncInit   = 1'b0;
	localparam logic FuncUpdate = 1'b1;

	localparam int ItemTarget    = 1550;
	localparam int HoldOffCycles = 300;
	localparam int StallLimit    = 3000;
	localparam int SettleCycles  = 8;

	class drive_predictor;
		cfg_t                    cfg;
		logic signed [ErrW-1:0]  err_now;
		logic signed [ErrW-1:0]  err_prev;
		logic signed [DataW-1:0] drive_reg;
		logic [DataW-1:0]        drive_q[$];
		int                      fails;

		function new();
			cfg.target         = '0;
			cfg.ts_over_ti     = '0;
			cfg.gain           = '0;
			cfg.gain_frac_bits = FracBitsReset;
			cfg.out_max        = OutMaxReset;
			cfg.out_min        = OutMinReset;
			cfg.invert         = 1'b0;
			err_now            = '0;
			err_prev           = '0;
			drive_reg          = '0;
			fails              = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DataW-1:0] value);
			case (idx)
				REG_TARGET:     cfg.target = value;
				REG_TS_OVER_TI: cfg.ts_over_ti = value[TsW-1:0];
				REG_GAIN:       cfg.gain = value;
				REG_FRAC_BITS:  cfg.gain_frac_bits = value[FracW-1:0];
				REG_OUT_MAX:    cfg.out_max = value;
				REG_OUT_MIN:    cfg.out_min = value;
				REG_INVERT:     cfg.invert = value[0];
				default:        ;
			endcase
		endfunction

		function void take_item(logic func, logic [DataW-1:0] sample);
			longint e0, e1, acc, g, hi, lo;
			int unsigned fb;
			e0 = longint'($signed(cfg.target)) - longint'($signed(sample));
			if (func == FuncInit) begin
				err_now = e0[ErrW-1:0];
			end else begin
				err_prev = err_now;
				err_now  = e0[ErrW-1:0];
				e1 = longint'(err_prev);
				// integral term rounded half up, then add the error difference
				acc = (e0 + e1) * longint'(cfg.ts_over_ti);
				acc = (acc + 64'sd32768) >>> IntShift;
				acc = acc + e0 - e1;
				g = longint'($signed(cfg.gain));
				if (cfg.invert && g > 0) begin
					g = -g;
				end
				acc = acc * g;
				fb = cfg.gain_frac_bits;
				if (fb > 0) begin
					acc = (acc + (longint'(1) <<< (fb - 1))) >>> fb;
				end
				acc = acc + longint'(drive_reg);
				if (acc > 32767) begin
					acc = 32767;
				end else if (acc < -32768) begin
					acc = -32768;
				end
				hi = longint'($signed(cfg.out_max));
				lo = longint'($signed(cfg.out_min));
				// upper clamp wins when the limits are crossed
				if (acc > hi) begin
					acc = hi;
				end else if (acc < lo) begin
					acc = lo;
				end
				drive_reg = acc[DataW-1:0];
			end
			drive_q.push_back(drive_reg);
		endfunction

		function void check_drive(logic [DataW-1:0] got);
			logic [DataW-1:0] want;
			if (drive_q.size() == 0) begin
				$error("drive: expected none, got %0d", $signed(got));
				fails++;
			end else begin
				want = drive_q.pop_front();
				if (got !== want) begin
					$error("drive: expected %0d, got %0d", $signed(want), $signed(got));
					fails++;
				end
			end
		endfunction

		function int pending();
			return drive_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [DataW-1:0]   s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [DataW-1:0]   m_tdata;
	logic               cfg_we = 1'b0;
	logic [IdxW-1:0]    cfg_index = '0;
	logic [DataW-1:0]   cfg_data = '0;

	drive_predictor pred = new();

	int          n_sent = 0;
	int          burst_left = 0;
	int          gap_max = 3;
	int          rx_mode = 0;
	logic [15:0] ready_pattern = 16'hA5C3;
	logic        hold_off_req = 1'b0;
	int          stall_cycles = 0;

	incremental_pi_controller_q15_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			pred.check_drive(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles == StallLimit) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// receiver: long hold-off on request, otherwise ready per the current mode
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: begin
					ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
					m_tready <= ready_pattern[0];
				end
				default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_item(input logic func, input logic [DataW-1:0] sample);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		pred.take_item(func, sample);
		n_sent++;
	endtask

	// sender works in bursts; drop valid for a random gap between them
	task automatic offer(input logic func, input logic [DataW-1:0] sample);
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_item(func, sample);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pred.pending() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// hold the write enable across the sequence and lower it once at the end
	task automatic put_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		pred.write_reg(idx, value);
	endtask

	task automatic apply_settings(input cfg_t c);
		put_reg(REG_TARGET, c.target);
		put_reg(REG_TS_OVER_TI, {1'b0, c.ts_over_ti});
		put_reg(REG_GAIN, c.gain);
		put_reg(REG_FRAC_BITS, {11'd0, c.gain_frac_bits});
		put_reg(REG_OUT_MAX, c.out_max);
		put_reg(REG_OUT_MIN, c.out_min);
		put_reg(REG_INVERT, {15'd0, c.invert});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [DataW-1:0] pick16();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfg_t rand_settings();
		cfg_t             c;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		c.target = pick16();
		case ($urandom_range(0, 3))
			0:       c.ts_over_ti = 15'h7FFF;
			1:       c.ts_over_ti = '0;
			default: c.ts_over_ti = 15'($urandom);
		endcase
		c.gain = pick16();
		case ($urandom_range(0, 7))
			0:       c.gain_frac_bits = 5'd0;
			1:       c.gain_frac_bits = 5'd31;
			2:       c.gain_frac_bits = 5'd1;
			3:       c.gain_frac_bits = 5'd30;
			default: c.gain_frac_bits = 5'($urandom_range(10, 20));
		endcase
		a = 16'($urandom);
		b = 16'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				c.out_max = 16'h7FFF;
				c.out_min = 16'h8000;
			end
			1: begin
				// crossed limits
				c.out_max = ($signed(a) < $signed(b)) ? a : b;
				c.out_min = ($signed(a) < $signed(b)) ? b : a;
			end
			default: begin
				c.out_max = ($signed(a) > $signed(b)) ? a : b;
				c.out_min = ($signed(a) > $signed(b)) ? b : a;
			end
		endcase
		c.invert = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic logic [DataW-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2, 3:    return pred.cfg.target + 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		phase = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero gain keeps the output at zero
		offer(FuncInit, 16'h8000);
		offer(FuncUpdate, 16'h7FFF);

		// full-scale error, largest coefficients, no fraction bits: saturate
		wait_idle();
		apply_settings(cfg_t'{16'h7FFF, 15'h7FFF, 16'h7FFF, 5'd0, 16'h7FFF, 16'h8000, 1'b0});
		offer(FuncInit, 16'h8000);
		offer(FuncUpdate, 16'h8000);
		offer(FuncUpdate, 16'h7FFF);
		offer(FuncUpdate, 16'h0000);

		// most negative gain with invert set stays negative; widest shift
		wait_idle();
		apply_settings(cfg_t'{16'h8000, 15'h0000, 16'h8000, 5'd31, 16'h7FFF, 16'h8000, 1'b1});
		offer(FuncUpdate, 16'h7FFF);
		offer(FuncUpdate, 16'h8000);
		offer(FuncInit, 16'h1234);
		offer(FuncUpdate, 16'h0000);

		// positive gain negated by invert
		wait_idle();
		apply_settings(cfg_t'{16'h0000, 15'h4000, 16'h4000, 5'd15, 16'h7FFF, 16'h8000, 1'b1});
		offer(FuncUpdate, 16'h1000);
		offer(FuncUpdate, 16'hF000);
		offer(FuncUpdate, 16'h0000);

		// crossed clamps: min above max
		wait_idle();
		apply_settings(cfg_t'{16'h0000, 15'h0800, 16'h7000, 5'd12, 16'hFC18, 16'h03E8, 1'b0});
		offer(FuncUpdate, 16'h4000);
		offer(FuncUpdate, 16'hC000);
		offer(FuncUpdate, 16'h0000);

		// one fraction bit: rounding of halves in both directions
		wait_idle();
		apply_settings(cfg_t'{16'h0000, 15'h0001, 16'h0001, 5'd1, 16'h7FFF, 16'h8000, 1'b0});
		offer(FuncUpdate, 16'h0001);
		offer(FuncUpdate, 16'hFFFF);
		offer(FuncUpdate, 16'h0002);
		offer(FuncUpdate, 16'h8000);

		// zero gain with invert set
		wait_idle();
		apply_settings(cfg_t'{16'h0001, 15'h7FFF, 16'h0000, 5'd30, 16'h7FFF, 16'h8000, 1'b1});
		offer(FuncUpdate, 16'h7FFF);
		offer(FuncUpdate, 16'h8000);

		while (n_sent < ItemTarget) begin
			wait_idle();
			apply_settings(rand_settings());
			rx_mode = $urandom_range(0, 2);
			ready_pattern = 16'($urandom) | 16'h0001;
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			// receiver holds off while the sender keeps offering: fill the block
			if (phase % 10 == 2) begin
				hold_off_req = 1'b1;
			end
			n = $urandom_range(20, 80);
			repeat (n) begin
				offer(($urandom_range(0, 4) != 0) ? FuncUpdate : FuncInit, rand_sample());
			end
			phase++;
		end

		wait_idle();
		if (pred.fails == 0 && pred.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
